[sv/tbam_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbam_pkg
// Shared codes, constants and record types of the tagged block allocation map.
// ----------------------------------------------------------------------------
package tbam_pkg;

    localparam logic [7:0]  FREE_MARK  = 8'hff;
    localparam logic [31:0] EXTRA_BASE = 32'h4010_8000;
    localparam int          RUN_MAX    = 64;

    // operation codes
    localparam logic [2:0] FN_ALLOC   = 3'd0;
    localparam logic [2:0] FN_RELEASE = 3'd1;
    localparam logic [2:0] FN_FREE    = 3'd2;
    localparam logic [2:0] FN_LOOKUP  = 3'd3;
    localparam logic [2:0] FN_PLACE   = 3'd4;
    localparam logic [2:0] FN_EXCH    = 3'd5;

    // status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_OOM     = 2'd1;
    localparam logic [1:0] ST_MISSING = 2'd2;

    // move codes
    localparam logic [1:0] MV_NONE = 2'd0;
    localparam logic [1:0] MV_COPY = 2'd1;
    localparam logic [1:0] MV_SWAP = 2'd2;

    // one buffered result, without the final used count
    typedef struct packed {
        logic [1:0] status;
        logic [7:0] eidx;
        logic [7:0] pidx;
        logic [1:0] move;
        logic       ev;
        logic       pv;
    } res_rec_t;

    // handoff from sequencer to result drain
    typedef struct packed {
        logic       start;
        logic [6:0] n;
        logic [6:0] used;
    } drain_cmd_t;

endpackage

[sv/tagged_block_allocation_map.sv]
`timescale 1ns / 1ps
// Each map walk reads one entry per cycle. The blocks of a run are handled in
// turn; a place walks the map when its home entry does not already match.
// Each result is read from the result buffer, then loaded into the output
// register; the next beat is taken once the last result is loaded into the
// output register.
// Reset clears the valid bits of the map (all entries free) and the used count.
// ----------------------------------------------------------------------------
// tagged_block_allocation_map
// Allocation table of physical memory blocks with owner and tag per entry.
// ----------------------------------------------------------------------------
module tagged_block_allocation_map
    import tbam_pkg::*;
#(
    parameter int MAP_ENTRIES = 64,
    parameter int BLOCK_BYTES = 512
)
(
    input  logic        clk,
    input  logic        rst_n,
    // input beats
    input  logic        s_tvalid,
    output logic        s_tready,
    // func[2:0], owner_slot[10:3], peer_slot[18:11], first_block[25:19],
    // block_count[32:26], zero fill above
    input  logic [39:0] s_tdata,
    // segment_kind[0]
    input  logic        s_tuser,
    // result beats
    output logic        m_tvalid,
    input  logic        m_tready,
    // status[1:0], entry_index[7:2], peer_index[13:8], move_kind[15:14],
    // entry_address[47:16], peer_address[79:48], used_blocks[86:80], zero [87]
    output logic [87:0] m_tdata,
    // last_of_run
    output logic        m_tlast,
    // configuration writes
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wdata
);

    localparam int IW = (MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1;
    localparam int CW = $clog2(MAP_ENTRIES + 1);

    localparam logic [1:0] CFG_DATA_BLOCKS = 2'd0;
    localparam logic [1:0] CFG_CODE_BLOCKS = 2'd1;
    localparam logic [1:0] CFG_DATA_BASE   = 2'd2;
    localparam logic [1:0] CFG_CODE_BASE   = 2'd3;

    logic [6:0]  drb_reg;
    logic [6:0]  crb_reg;
    logic [31:0] dbase_reg;
    logic [31:0] cbase_reg;

    logic          rd_en;
    logic [IW-1:0] rd_addr;
    logic [15:0]   rd_data;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    logic [15:0]   wr_data;
    logic          push_en;
    logic [5:0]    push_addr;
    res_rec_t      push_rec;
    drain_cmd_t    cmd;
    logic          drain_busy;

    logic [1:0]  status;
    logic [5:0]  entry_index;
    logic [5:0]  peer_index;
    logic [1:0]  move_kind;
    logic [31:0] entry_address;
    logic [31:0] peer_address;
    logic [6:0]  used_blocks;

    // Layout registers: user writes only while the block is idle; not enforced.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drb_reg   <= 7'd16;
            crb_reg   <= 7'd16;
            dbase_reg <= 32'd0;
            cbase_reg <= 32'd0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DATA_BLOCKS: drb_reg   <= cfg_wdata[6:0];
                CFG_CODE_BLOCKS: crb_reg   <= cfg_wdata[6:0];
                CFG_DATA_BASE:   dbase_reg <= cfg_wdata;
                CFG_CODE_BASE:   cbase_reg <= cfg_wdata;
                default:         drb_reg   <= drb_reg;
            endcase
        end
    end

    // Map storage: owner in the upper byte, tag in the lower byte.
    tbam_map_mem #(
        .MAP_ENTRIES (MAP_ENTRIES),
        .IW          (IW)
    ) u_map (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    // Sequencer: scan, edit and push one result per block of the run.
    tbam_seq #(
        .MAP_ENTRIES (MAP_ENTRIES),
        .IW          (IW),
        .CW          (CW)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .func       (s_tdata[2:0]),
        .owner      (s_tdata[10:3]),
        .peer       (s_tdata[18:11]),
        .kind       (s_tuser),
        .first      (s_tdata[25:19]),
        .count      (s_tdata[32:26]),
        .drb        (drb_reg),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .push_en    (push_en),
        .push_addr  (push_addr),
        .push_rec   (push_rec),
        .drain_busy (drain_busy),
        .cmd        (cmd)
    );

    // Hold results until the operation ends so each carries the final count.
    tbam_res_buf #(
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_res (
        .clk           (clk),
        .rst_n         (rst_n),
        .push_en       (push_en),
        .push_addr     (push_addr),
        .push_rec      (push_rec),
        .cmd           (cmd),
        .busy          (drain_busy),
        .drb           (drb_reg),
        .crb           (crb_reg),
        .dbase         (dbase_reg),
        .cbase         (cbase_reg),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .status        (status),
        .entry_index   (entry_index),
        .peer_index    (peer_index),
        .move_kind     (move_kind),
        .entry_address (entry_address),
        .peer_address  (peer_address),
        .used_blocks   (used_blocks),
        .last_of_run   (m_tlast)
    );

    // Pack the result beat, lowest field first.
    assign m_tdata = {1'b0, used_blocks, peer_address, entry_address, move_kind,
                      peer_index, entry_index, status};

endmodule

[sv/tbam_map_mem.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbam_map_mem
// Map storage: owner and tag per entry, one write and one registered read port.
// ----------------------------------------------------------------------------
module tbam_map_mem
#(
    parameter int MAP_ENTRIES = 64,
    parameter int IW          = 6
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          rd_en,
    input  logic [IW-1:0] rd_addr,
    output logic [15:0]   rd_data,
    input  logic          wr_en,
    input  logic [IW-1:0] wr_addr,
    input  logic [15:0]   wr_data
);

    logic [15:0] mem [MAP_ENTRIES];
    logic [MAP_ENTRIES-1:0] vld_reg;
    logic [15:0] rd_reg;
    logic        rvld_reg;

    // entries never written read as free
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            rvld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rvld_reg <= vld_reg[rd_addr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rvld_reg ? rd_reg : 16'hffff;

endmodule

[sv/tbam_seq.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbam_seq
// Operation sequencer: scans the map, edits entries and pushes results.
// ----------------------------------------------------------------------------
module tbam_seq
    import tbam_pkg::*;
#(
    parameter int MAP_ENTRIES = 64,
    parameter int IW          = 6,
    parameter int CW          = 7
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [2:0]       func,
    input  logic [7:0]       owner,
    input  logic [7:0]       peer,
    input  logic             kind,
    input  logic [6:0]       first,
    input  logic [6:0]       count,
    input  logic [6:0]       drb,
    output logic             rd_en,
    output logic [IW-1:0]    rd_addr,
    input  logic [15:0]      rd_data,
    output logic             wr_en,
    output logic [IW-1:0]    wr_addr,
    output logic [15:0]      wr_data,
    output logic             push_en,
    output logic [5:0]       push_addr,
    output res_rec_t         push_rec,
    input  logic             drain_busy,
    output drain_cmd_t       cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_START, S_BLOCK, S_PL_CHK, S_SCAN_INIT, S_SCAN,
        S_POST, S_WR_B, S_NEXT, S_FINISH
    } state_t;

    typedef enum logic [1:0] {M_ALLOC, M_FIND, M_PAIR, M_FREE} mode_t;

    state_t         state_reg, state_next;
    mode_t          mode_reg, mode_next;
    logic [2:0]     func_reg, func_next;
    logic [7:0]     owner_reg, owner_next;
    logic [7:0]     peer_reg, peer_next;
    logic           kind_reg, kind_next;
    logic [6:0]     blk_reg, blk_next;
    logic [6:0]     left_reg, left_next;
    logic [6:0]     n_reg, n_next;
    logic [CW-1:0]  used_reg, used_next;
    logic [CW-1:0]  ptr_reg, ptr_next;
    logic           pend_reg, pend_next;
    logic [IW-1:0]  pidx_reg, pidx_next;
    logic           ha_reg, ha_next;
    logic           hb_reg, hb_next;
    logic [IW-1:0]  ia_reg, ia_next;
    logic [IW-1:0]  ib_reg, ib_next;
    logic [IW-1:0]  home_reg, home_next;
    logic [15:0]    hdata_reg, hdata_next;
    drain_cmd_t     cmd_reg, cmd_next;

    logic [7:0] tag;
    logic [7:0] d_own;
    logic [7:0] d_tag;
    logic [7:0] home_w;
    logic       match_a;
    logic       match_b;
    logic       last;

    assign tag      = {kind_reg, blk_reg};
    assign d_own    = rd_data[15:8];
    assign d_tag    = rd_data[7:0];
    assign home_w   = {1'b0, blk_reg} + (kind_reg ? {1'b0, drb} : 8'd0);
    assign match_a  = (owner_reg != FREE_MARK) && (d_own == owner_reg) && (d_tag == tag);
    assign match_b  = (peer_reg != FREE_MARK) && (d_own == peer_reg) && (d_tag == tag);
    assign last     = (pidx_reg == IW'(MAP_ENTRIES - 1));
    assign in_ready = (state_reg == S_IDLE) && !drain_busy;
    assign cmd      = cmd_reg;
    assign push_addr = n_reg[5:0];

    always_comb
    begin
        state_next = state_reg;
        mode_next  = mode_reg;
        func_next  = func_reg;
        owner_next = owner_reg;
        peer_next  = peer_reg;
        kind_next  = kind_reg;
        blk_next   = blk_reg;
        left_next  = left_reg;
        n_next     = n_reg;
        used_next  = used_reg;
        ptr_next   = ptr_reg;
        pend_next  = pend_reg;
        pidx_next  = pidx_reg;
        ha_next    = ha_reg;
        hb_next    = hb_reg;
        ia_next    = ia_reg;
        ib_next    = ib_reg;
        home_next  = home_reg;
        hdata_next = hdata_reg;
        cmd_next   = '0;
        cmd_next.n    = cmd_reg.n;
        cmd_next.used = cmd_reg.used;
        rd_en      = 1'b0;
        rd_addr    = ptr_reg[IW-1:0];
        wr_en      = 1'b0;
        wr_addr    = ia_reg;
        wr_data    = 16'hffff;
        push_en    = 1'b0;
        push_rec   = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && !drain_busy)
                begin
                    func_next  = func;
                    owner_next = owner;
                    peer_next  = peer;
                    kind_next  = kind;
                    blk_next   = first;
                    left_next  = (count > 7'(RUN_MAX)) ? 7'(RUN_MAX) : count;
                    n_next     = '0;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                case (func_reg)
                    FN_FREE:
                    begin
                        mode_next  = M_FREE;
                        state_next = S_SCAN_INIT;
                    end
                    FN_LOOKUP:
                    begin
                        mode_next  = M_FIND;
                        state_next = S_SCAN_INIT;
                    end
                    FN_ALLOC, FN_RELEASE, FN_PLACE, FN_EXCH:
                    begin
                        if (func_reg == FN_ALLOC && owner_reg == FREE_MARK)
                        begin
                            push_en         = 1'b1;
                            push_rec.status = ST_MISSING;
                            n_next          = n_reg + 7'd1;
                            state_next      = S_FINISH;
                        end
                        else if (left_reg == '0)
                        begin
                            push_en    = 1'b1;
                            n_next     = n_reg + 7'd1;
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            state_next = S_BLOCK;
                        end
                    end
                    default:
                    begin
                        push_en    = 1'b1;
                        n_next     = n_reg + 7'd1;
                        state_next = S_FINISH;
                    end
                endcase
            end
            S_BLOCK:
            begin
                case (func_reg)
                    FN_ALLOC:
                    begin
                        mode_next  = M_ALLOC;
                        state_next = S_SCAN_INIT;
                    end
                    FN_EXCH:
                    begin
                        mode_next  = M_PAIR;
                        state_next = S_SCAN_INIT;
                    end
                    FN_PLACE:
                    begin
                        if (home_w >= 8'(MAP_ENTRIES))
                        begin
                            push_en         = 1'b1;
                            push_rec.status = ST_MISSING;
                            n_next          = n_reg + 7'd1;
                            state_next      = S_FINISH;
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = home_w[IW-1:0];
                            home_next  = home_w[IW-1:0];
                            state_next = S_PL_CHK;
                        end
                    end
                    default:
                    begin
                        mode_next  = M_FIND;
                        state_next = S_SCAN_INIT;
                    end
                endcase
            end
            S_PL_CHK:
            begin
                hdata_next = rd_data;
                if (match_a)
                begin
                    push_en       = 1'b1;
                    push_rec.eidx = 8'(home_reg);
                    push_rec.pidx = 8'(home_reg);
                    push_rec.ev   = 1'b1;
                    push_rec.pv   = 1'b1;
                    n_next        = n_reg + 7'd1;
                    state_next    = S_NEXT;
                end
                else
                begin
                    mode_next  = M_FIND;
                    state_next = S_SCAN_INIT;
                end
            end
            S_SCAN_INIT:
            begin
                ptr_next   = '0;
                pend_next  = 1'b0;
                ha_next    = 1'b0;
                hb_next    = 1'b0;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                // issue one read per cycle, judge the entry read last cycle
                if (ptr_reg < CW'(MAP_ENTRIES))
                begin
                    rd_en     = 1'b1;
                    ptr_next  = ptr_reg + CW'(1);
                    pend_next = 1'b1;
                    pidx_next = ptr_reg[IW-1:0];
                end
                else
                begin
                    pend_next = 1'b0;
                end
                if (pend_reg)
                begin
                    case (mode_reg)
                        M_ALLOC:
                        begin
                            if (d_own == FREE_MARK)
                            begin
                                ha_next    = 1'b1;
                                ia_next    = pidx_reg;
                                state_next = S_POST;
                            end
                            else if (last)
                            begin
                                state_next = S_POST;
                            end
                        end
                        M_FIND:
                        begin
                            if (match_a)
                            begin
                                ha_next    = 1'b1;
                                ia_next    = pidx_reg;
                                state_next = S_POST;
                            end
                            else if (last)
                            begin
                                state_next = S_POST;
                            end
                        end
                        M_PAIR:
                        begin
                            if (match_a && !ha_reg)
                            begin
                                ha_next = 1'b1;
                                ia_next = pidx_reg;
                            end
                            if (match_b && !hb_reg)
                            begin
                                hb_next = 1'b1;
                                ib_next = pidx_reg;
                            end
                            if (((ha_reg || match_a) && (hb_reg || match_b)) || last)
                            begin
                                state_next = S_POST;
                            end
                        end
                        default:
                        begin
                            if (owner_reg != FREE_MARK && d_own == owner_reg)
                            begin
                                wr_en     = 1'b1;
                                wr_addr   = pidx_reg;
                                used_next = used_reg - CW'(1);
                            end
                            if (last)
                            begin
                                state_next = S_POST;
                            end
                        end
                    endcase
                end
            end
            S_POST:
            begin
                push_en = 1'b1;
                n_next  = n_reg + 7'd1;
                case (func_reg)
                    FN_LOOKUP:
                    begin
                        push_rec.status = ha_reg ? ST_OK : ST_MISSING;
                        push_rec.eidx   = ha_reg ? 8'(ia_reg) : 8'd0;
                        push_rec.ev     = ha_reg;
                        state_next      = S_FINISH;
                    end
                    FN_ALLOC:
                    begin
                        if (!ha_reg)
                        begin
                            push_rec.status = ST_OOM;
                            state_next      = S_FINISH;
                        end
                        else
                        begin
                            wr_en         = 1'b1;
                            wr_data       = {owner_reg, tag};
                            used_next     = used_reg + CW'(1);
                            push_rec.eidx = 8'(ia_reg);
                            push_rec.ev   = 1'b1;
                            state_next    = S_NEXT;
                        end
                    end
                    FN_RELEASE:
                    begin
                        if (!ha_reg)
                        begin
                            push_rec.status = ST_MISSING;
                            state_next      = S_FINISH;
                        end
                        else
                        begin
                            wr_en         = 1'b1;
                            used_next     = used_reg - CW'(1);
                            push_rec.eidx = 8'(ia_reg);
                            push_rec.ev   = 1'b1;
                            state_next    = S_NEXT;
                        end
                    end
                    FN_EXCH:
                    begin
                        if (!(ha_reg && hb_reg))
                        begin
                            push_rec.status = ST_MISSING;
                            state_next      = S_FINISH;
                        end
                        else
                        begin
                            wr_en         = 1'b1;
                            wr_data       = {peer_reg, tag};
                            push_rec.eidx = 8'(ia_reg);
                            push_rec.pidx = 8'(ib_reg);
                            push_rec.ev   = 1'b1;
                            push_rec.pv   = 1'b1;
                            push_rec.move = MV_COPY;
                            state_next    = S_WR_B;
                        end
                    end
                    FN_PLACE:
                    begin
                        if (!ha_reg)
                        begin
                            push_rec.status = ST_MISSING;
                            state_next      = S_FINISH;
                        end
                        else
                        begin
                            wr_en         = 1'b1;
                            wr_addr       = home_reg;
                            wr_data       = {owner_reg, tag};
                            push_rec.eidx = 8'(home_reg);
                            push_rec.pidx = 8'(ia_reg);
                            push_rec.ev   = 1'b1;
                            push_rec.pv   = 1'b1;
                            push_rec.move = (hdata_reg[15:8] == FREE_MARK) ? MV_COPY
                                                                           : MV_SWAP;
                            state_next    = S_WR_B;
                        end
                    end
                    default:
                    begin
                        state_next = S_FINISH;
                    end
                endcase
            end
            S_WR_B:
            begin
                wr_en = 1'b1;
                if (func_reg == FN_PLACE)
                begin
                    wr_addr = ia_reg;
                    wr_data = hdata_reg;
                end
                else
                begin
                    wr_addr = ib_reg;
                    wr_data = {owner_reg, tag};
                end
                state_next = S_NEXT;
            end
            S_NEXT:
            begin
                blk_next  = blk_reg + 7'd1;
                left_next = left_reg - 7'd1;
                state_next = (left_reg == 7'd1) ? S_FINISH : S_BLOCK;
            end
            S_FINISH:
            begin
                if (!drain_busy)
                begin
                    cmd_next.start = 1'b1;
                    cmd_next.n     = n_reg;
                    cmd_next.used  = used_reg[6:0];
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            used_reg  <= '0;
            pend_reg  <= 1'b0;
            cmd_reg   <= '0;
            n_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
            pend_reg  <= pend_next;
            cmd_reg   <= cmd_next;
            n_reg     <= n_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg  <= mode_next;
        func_reg  <= func_next;
        owner_reg <= owner_next;
        peer_reg  <= peer_next;
        kind_reg  <= kind_next;
        blk_reg   <= blk_next;
        left_reg  <= left_next;
        ptr_reg   <= ptr_next;
        pidx_reg  <= pidx_next;
        ha_reg    <= ha_next;
        hb_reg    <= hb_next;
        ia_reg    <= ia_next;
        ib_reg    <= ib_next;
        home_reg  <= home_next;
        hdata_reg <= hdata_next;
    end

    a_wr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> ({1'b0, wr_addr} < (IW+1)'(MAP_ENTRIES)))
        else $error("map write outside table");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push_en |-> (n_reg < 7'(RUN_MAX)))
        else $error("result buffer overflow");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_START))
        else $error("accepted beat did not start an operation");

endmodule

[sv/tbam_res_buf.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbam_res_buf
// Result buffer and drain: holds one operation's results, then sends them
// with the final used count and the region addresses.
// ----------------------------------------------------------------------------
module tbam_res_buf
    import tbam_pkg::*;
#(
    parameter int BLOCK_BYTES = 512
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push_en,
    input  logic [5:0]  push_addr,
    input  res_rec_t    push_rec,
    input  drain_cmd_t  cmd,
    output logic        busy,
    input  logic [6:0]  drb,
    input  logic [6:0]  crb,
    input  logic [31:0] dbase,
    input  logic [31:0] cbase,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [5:0]  entry_index,
    output logic [5:0]  peer_index,
    output logic [1:0]  move_kind,
    output logic [31:0] entry_address,
    output logic [31:0] peer_address,
    output logic [6:0]  used_blocks,
    output logic        last_of_run
);

    typedef enum logic [1:0] {D_IDLE, D_RD, D_LD} dstate_t;

    dstate_t    dstate_reg;
    res_rec_t   buf_mem [RUN_MAX];
    res_rec_t   rd_reg;
    logic [6:0] total_reg;
    logic [5:0] ptr_reg;
    logic [6:0] used_reg;
    logic       ovalid_reg;
    logic [1:0]  status_reg;
    logic [5:0]  eidx_reg;
    logic [5:0]  pidx_reg;
    logic [1:0]  move_reg;
    logic [31:0] eaddr_reg;
    logic [31:0] paddr_reg;
    logic        last_reg;
    logic        is_last;

    function automatic logic [31:0] addr_of(input logic [7:0] idx, input logic [6:0] nd,
                                            input logic [6:0] nc, input logic [31:0] bd,
                                            input logic [31:0] bc);
        logic [8:0]  i9;
        logic [8:0]  j9;
        logic [8:0]  off;
        logic [31:0] base;
        i9 = {1'b0, idx};
        j9 = i9 - {2'b0, nd};
        if (i9 < {2'b0, nd})
        begin
            off  = i9;
            base = bd;
        end
        else if (j9 < {2'b0, nc})
        begin
            off  = j9;
            base = bc;
        end
        else
        begin
            off  = j9 - {2'b0, nc};
            base = EXTRA_BASE;
        end
        return base + 32'(32'(off) * 32'(BLOCK_BYTES));
    endfunction

    // a pending start counts as busy so no new operation overwrites the buffer
    assign busy    = (dstate_reg != D_IDLE) || cmd.start;
    assign is_last = ({1'b0, ptr_reg} == (total_reg - 7'd1));

    always_ff @(posedge clk)
    begin
        if (push_en)
        begin
            buf_mem[push_addr] <= push_rec;
        end
        if (dstate_reg == D_RD)
        begin
            rd_reg <= buf_mem[ptr_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dstate_reg <= D_IDLE;
            ovalid_reg <= 1'b0;
            total_reg  <= '0;
            ptr_reg    <= '0;
            used_reg   <= '0;
            status_reg <= '0;
            eidx_reg   <= '0;
            pidx_reg   <= '0;
            move_reg   <= '0;
            eaddr_reg  <= '0;
            paddr_reg  <= '0;
            last_reg   <= 1'b0;
        end
        else
        begin
            if (ovalid_reg && out_ready && (dstate_reg != D_LD))
            begin
                ovalid_reg <= 1'b0;
            end
            unique case (dstate_reg)
                D_IDLE:
                begin
                    if (cmd.start)
                    begin
                        total_reg  <= cmd.n;
                        used_reg   <= cmd.used;
                        ptr_reg    <= '0;
                        dstate_reg <= D_RD;
                    end
                end
                D_RD:
                begin
                    dstate_reg <= D_LD;
                end
                D_LD:
                begin
                    if (!ovalid_reg || out_ready)
                    begin
                        ovalid_reg <= 1'b1;
                        status_reg <= rd_reg.status;
                        eidx_reg   <= rd_reg.eidx[5:0];
                        pidx_reg   <= rd_reg.pidx[5:0];
                        move_reg   <= rd_reg.move;
                        eaddr_reg  <= rd_reg.ev ? addr_of(rd_reg.eidx, drb, crb, dbase, cbase)
                                                : 32'd0;
                        paddr_reg  <= rd_reg.pv ? addr_of(rd_reg.pidx, drb, crb, dbase, cbase)
                                                : 32'd0;
                        last_reg   <= is_last;
                        if (is_last)
                        begin
                            dstate_reg <= D_IDLE;
                        end
                        else
                        begin
                            ptr_reg    <= ptr_reg + 6'd1;
                            dstate_reg <= D_RD;
                        end
                    end
                end
                default:
                begin
                    dstate_reg <= D_IDLE;
                end
            endcase
        end
    end

    assign out_valid     = ovalid_reg;
    assign status        = status_reg;
    assign entry_index   = eidx_reg;
    assign peer_index    = pidx_reg;
    assign move_kind     = move_reg;
    assign entry_address = eaddr_reg;
    assign peer_address  = paddr_reg;
    assign used_blocks   = used_reg;
    assign last_of_run   = last_reg;

    a_start_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |-> (dstate_reg == D_IDLE))
        else $error("drain started while busy");

    a_push_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        push_en |-> (dstate_reg == D_IDLE))
        else $error("result written while drain reads buffer");

    a_total_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |-> (cmd.n != 7'd0))
        else $error("operation handed off with no result");

endmodule

[test/tb_tagged_block_allocation_map.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tagged_block_allocation_map
// Self-checking bench for the block allocation map. A directed table walks
// the operations and corner cases. Random traffic follows, in four register
// settings, under changing idle patterns on both streams. Each result beat is
// checked field by field against an in-bench model of the map.
// ----------------------------------------------------------------------------
module tb_tagged_block_allocation_map;
    import tbam_pkg::*;

    localparam int ENTRIES     = 64;
    localparam int BLK_BYTES   = 512;
    localparam int WATCHDOG    = 40000;   // cycles with no beat on either side
    localparam int HOLD_CYCLES = 2500;    // long receiver back-pressure stretch
    localparam int RAND_ITEMS  = 156;
    localparam int PHASES      = 4;
    localparam logic [2:0] FN_COUNT  = 3'd6;
    localparam logic [2:0] FN_UNUSED = 3'd7;
    localparam logic [1:0] REG_DATA_BLKS = 2'd0;
    localparam logic [1:0] REG_CODE_BLKS = 2'd1;
    localparam logic [1:0] REG_DATA_BASE = 2'd2;
    localparam logic [1:0] REG_CODE_BASE = 2'd3;

    typedef struct {
        logic [2:0] func;
        logic [7:0] owner;
        logic [7:0] peer;
        logic       kind;
        logic [6:0] first;
        logic [6:0] count;
    } map_op_t;

    typedef struct {
        logic [1:0]  status;
        logic [5:0]  eidx;
        logic [5:0]  pidx;
        logic [1:0]  move;
        logic [31:0] eaddr;
        logic [31:0] paddr;
        logic [6:0]  used;
        logic        last;
    } map_result_t;

    typedef struct {
        map_op_t    op;
        bit         chk;       // typed status of the first result applies
        logic [1:0] status;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;     // func, owner_slot, peer_slot, first_block, block_count
    logic        s_tuser;     // segment_kind
    logic        m_tvalid;
    logic        m_tready;
    logic [87:0] m_tdata;     // status, entry_index, peer_index, move_kind,
                              // entry_address, peer_address, used_blocks
    logic        m_tlast;     // last_of_run
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_wdata;

    // model of the map and its registers
    logic [7:0]  map_owner [ENTRIES];
    logic [7:0]  map_tag   [ENTRIES];
    logic [6:0]  map_used;
    logic [6:0]  data_blks, code_blks;
    logic [31:0] data_base, code_base;

    map_result_t pending_q[$];
    dir_row_t    dir_q[$];

    int  tx_idle_pct, rx_idle_pct;
    bit  hold_go, hold_rx;
    int  errors, mismatches, items_sent, beats_seen, quiet_cycles;

    tagged_block_allocation_map dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // ------------------------------------------------------------------
    // model of the map
    // ------------------------------------------------------------------
    function automatic logic [31:0] region_addr(int i);
        int off;
        off = i;
        if (off < data_blks)
            return data_base + BLK_BYTES * off;
        off -= data_blks;
        if (off < code_blks)
            return code_base + BLK_BYTES * off;
        off -= code_blks;
        return EXTRA_BASE + BLK_BYTES * off;
    endfunction

    function automatic int find_slot(logic [7:0] owner, logic [7:0] tag);
        if (owner == FREE_MARK)
            return -1;
        for (int i = 0; i < ENTRIES; i++)
            if (map_owner[i] == owner && map_tag[i] == tag)
                return i;
        return -1;
    endfunction

    function automatic map_result_t make_result(logic [1:0] st, int ei, int pi,
                                                logic [1:0] mv);
        map_result_t r;
        r.status = st;
        r.eidx   = (ei >= 0) ? ei[5:0] : 6'd0;
        r.pidx   = (pi >= 0) ? pi[5:0] : 6'd0;
        r.move   = mv;
        r.eaddr  = (ei >= 0) ? region_addr(ei) : 32'd0;
        r.paddr  = (pi >= 0) ? region_addr(pi) : 32'd0;
        r.used   = 7'd0;
        r.last   = 1'b0;
        return r;
    endfunction

    task automatic swap_slots(int a, int b);
        logic [7:0] o, t;
        o = map_owner[a];
        t = map_tag[a];
        map_owner[a] = map_owner[b];
        map_tag[a]   = map_tag[b];
        map_owner[b] = o;
        map_tag[b]   = t;
    endtask

    // apply one operation to the model, queue its results
    task automatic predict_map_op(input map_op_t op, output logic [1:0] first_st);
        map_result_t run_q[$];
        logic [7:0]  tag;
        logic [6:0]  blk;
        int          cnt, a, b, home;
        cnt = (op.count > RUN_MAX) ? RUN_MAX : op.count;
        if (op.func == FN_FREE)
        begin
            if (op.owner != FREE_MARK)
                for (int i = 0; i < ENTRIES; i++)
                    if (map_owner[i] == op.owner)
                    begin
                        map_owner[i] = FREE_MARK;
                        map_tag[i]   = FREE_MARK;
                        map_used--;
                    end
            run_q.push_back(make_result(ST_OK, -1, -1, MV_NONE));
        end
        else if (op.func == FN_LOOKUP)
        begin
            a = find_slot(op.owner, {op.kind, op.first});
            run_q.push_back(make_result((a >= 0) ? ST_OK : ST_MISSING, a, -1, MV_NONE));
        end
        else if (op.func == FN_ALLOC && op.owner == FREE_MARK)
            run_q.push_back(make_result(ST_MISSING, -1, -1, MV_NONE));
        else if (op.func == FN_ALLOC || op.func == FN_RELEASE ||
                 op.func == FN_PLACE || op.func == FN_EXCH)
        begin
            for (int k = 0; k < cnt; k++)
            begin
                blk = op.first + k[6:0];
                tag = {op.kind, blk};
                if (op.func == FN_ALLOC)
                begin
                    a = -1;
                    for (int i = 0; i < ENTRIES; i++)
                        if (map_owner[i] == FREE_MARK)
                        begin
                            a = i;
                            break;
                        end
                    if (a < 0)
                    begin
                        run_q.push_back(make_result(ST_OOM, -1, -1, MV_NONE));
                        break;
                    end
                    map_owner[a] = op.owner;
                    map_tag[a]   = tag;
                    map_used++;
                    run_q.push_back(make_result(ST_OK, a, -1, MV_NONE));
                end
                else if (op.func == FN_RELEASE)
                begin
                    a = find_slot(op.owner, tag);
                    if (a < 0)
                    begin
                        run_q.push_back(make_result(ST_MISSING, -1, -1, MV_NONE));
                        break;
                    end
                    map_owner[a] = FREE_MARK;
                    map_tag[a]   = FREE_MARK;
                    map_used--;
                    run_q.push_back(make_result(ST_OK, a, -1, MV_NONE));
                end
                else if (op.func == FN_PLACE)
                begin
                    home = blk + (op.kind ? int'(data_blks) : 0);
                    if (home >= ENTRIES)
                    begin
                        run_q.push_back(make_result(ST_MISSING, -1, -1, MV_NONE));
                        break;
                    end
                    if (op.owner != FREE_MARK && map_owner[home] == op.owner &&
                        map_tag[home] == tag)
                    begin
                        run_q.push_back(make_result(ST_OK, home, home, MV_NONE));
                        continue;
                    end
                    b = find_slot(op.owner, tag);
                    if (b < 0)
                    begin
                        run_q.push_back(make_result(ST_MISSING, -1, -1, MV_NONE));
                        break;
                    end
                    run_q.push_back(make_result(ST_OK, home, b,
                        (map_owner[home] == FREE_MARK) ? MV_COPY : MV_SWAP));
                    swap_slots(home, b);
                end
                else
                begin
                    a = find_slot(op.owner, tag);
                    b = find_slot(op.peer, tag);
                    if (a < 0 || b < 0)
                    begin
                        run_q.push_back(make_result(ST_MISSING, -1, -1, MV_NONE));
                        break;
                    end
                    swap_slots(a, b);
                    run_q.push_back(make_result(ST_OK, a, b, MV_COPY));
                end
            end
            // empty run still answers once
            if (run_q.size() == 0)
                run_q.push_back(make_result(ST_OK, -1, -1, MV_NONE));
        end
        else
            run_q.push_back(make_result(ST_OK, -1, -1, MV_NONE));

        first_st = run_q[0].status;
        run_q[$].last = 1'b1;
        foreach (run_q[k])
        begin
            run_q[k].used = map_used;
            pending_q.push_back(run_q[k]);
        end
    endtask

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic map_op_t mk_op(logic [2:0] f, logic [7:0] o, logic [7:0] p,
                                      logic k, logic [6:0] fb, logic [6:0] c);
        map_op_t op;
        op.func = f; op.owner = o; op.peer = p; op.kind = k; op.first = fb; op.count = c;
        return op;
    endfunction

    task automatic add_row(map_op_t op, bit chk, logic [1:0] st);
        dir_row_t r;
        r.op = op; r.chk = chk; r.status = st;
        dir_q.push_back(r);
    endtask

    function automatic logic [7:0] pick_slot();
        int r;
        r = $urandom_range(0, 99);
        if (r < 88)
            return 8'($urandom_range(0, 3));
        if (r < 92)
            return 8'd254;
        if (r < 95)
            return FREE_MARK;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic map_op_t rand_op();
        map_op_t op;
        int r;
        r = $urandom_range(0, 99);
        if (r < 30)      op.func = FN_ALLOC;
        else if (r < 46) op.func = FN_RELEASE;
        else if (r < 53) op.func = FN_FREE;
        else if (r < 64) op.func = FN_LOOKUP;
        else if (r < 78) op.func = FN_PLACE;
        else if (r < 90) op.func = FN_EXCH;
        else if (r < 96) op.func = FN_COUNT;
        else             op.func = FN_UNUSED;
        op.owner = pick_slot();
        op.peer  = pick_slot();
        op.kind  = 1'($urandom_range(0, 1));
        op.first = ($urandom_range(0, 99) < 80) ? 7'($urandom_range(0, 15))
                                                : 7'($urandom_range(0, 127));
        r = $urandom_range(0, 99);
        if (r < 85)      op.count = 7'($urandom_range(0, 6));
        else if (r < 95) op.count = 7'($urandom_range(7, 20));
        else if (r < 99) op.count = 7'd64;
        else             op.count = 7'($urandom_range(65, 127));
        return op;
    endfunction

    // offer one beat and hold it until taken
    task automatic send_op(map_op_t op, bit chk, logic [1:0] st);
        logic [1:0] got;
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, op.count, op.first, op.peer, op.owner, op.func};
        s_tuser  <= op.kind;
        do
            @(posedge clk);
        while (!s_tready);
        predict_map_op(op, got);
        items_sent++;
        if (chk && got !== st)
        begin
            errors++;
            $display("table row: status of first result %0d, typed %0d", got, st);
        end
    endtask

    task automatic drain_wait();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_q.size() != 0)
            @(posedge clk);
        // an operation may still be finishing its map walk
        repeat (2 * ENTRIES) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
    endtask

    task automatic write_regs(logic [6:0] db, logic [6:0] cb, logic [31:0] dbase,
                              logic [31:0] cbase);
        write_reg(REG_DATA_BLKS, {25'd0, db});
        write_reg(REG_CODE_BLKS, {25'd0, cb});
        write_reg(REG_DATA_BASE, dbase);
        write_reg(REG_CODE_BASE, cbase);
        @(negedge clk);
        cfg_we <= 1'b0;
        data_blks = db; code_blks = cb; data_base = dbase; code_base = cbase;
    endtask

    // ------------------------------------------------------------------
    // result side: ready pattern, long hold-off, checking, watchdog
    // ------------------------------------------------------------------
    always @(negedge clk)
        m_tready <= !hold_rx && ($urandom_range(0, 99) >= rx_idle_pct);

    initial
    begin
        hold_rx = 1'b0;
        wait (hold_go);
        hold_rx = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_rx = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            beats_seen++;
            if (pending_q.size() == 0)
            begin
                errors++;
                $display("result beat with nothing pending: %h", m_tdata);
            end
            else
            begin
                map_result_t e;
                bit bad;
                e = pending_q.pop_front();
                bad = (m_tdata[1:0]   !== e.status) || (m_tdata[7:2]   !== e.eidx) ||
                      (m_tdata[13:8]  !== e.pidx)   || (m_tdata[15:14] !== e.move) ||
                      (m_tdata[47:16] !== e.eaddr)  || (m_tdata[79:48] !== e.paddr) ||
                      (m_tdata[86:80] !== e.used)   || (m_tdata[87]    !== 1'b0) ||
                      (m_tlast        !== e.last);
                if (bad)
                begin
                    errors++;
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp st%0d e%0d p%0d mv%0d ea%h pa%h u%0d l%0d | got st%0d e%0d p%0d mv%0d ea%h pa%h u%0d l%0d",
                            e.status, e.eidx, e.pidx, e.move, e.eaddr, e.paddr, e.used, e.last,
                            m_tdata[1:0], m_tdata[7:2], m_tdata[13:8], m_tdata[15:14],
                            m_tdata[47:16], m_tdata[79:48], m_tdata[86:80], m_tlast);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG)
            begin
                $display("watchdog: no beat for %0d cycles, %0d results pending",
                         quiet_cycles, pending_q.size());
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0; s_tdata = '0; s_tuser = 1'b0; m_tready = 1'b0;
        cfg_we = 1'b0; cfg_index = REG_DATA_BLKS; cfg_wdata = '0;
        tx_idle_pct = 26; rx_idle_pct = 86;
        hold_go = 1'b0;
        errors = 0; mismatches = 0; items_sent = 0; beats_seen = 0; quiet_cycles = 0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            map_owner[i] = FREE_MARK;
            map_tag[i]   = FREE_MARK;
        end
        map_used = 7'd0;
        data_blks = 7'd16; code_blks = 7'd16; data_base = 32'd0; code_base = 32'd0;

        // directed table; typed status where it is plain from the operation
        add_row(mk_op(FN_COUNT,   8'd0,   8'd0, 1'b0, 7'd0,   7'd0),   1, ST_OK);
        add_row(mk_op(FN_LOOKUP,  8'd0,   8'd0, 1'b0, 7'd0,   7'd1),   1, ST_MISSING);
        add_row(mk_op(FN_RELEASE, 8'd0,   8'd0, 1'b0, 7'd0,   7'd1),   1, ST_MISSING);
        add_row(mk_op(FN_ALLOC,   FREE_MARK, 8'd0, 1'b0, 7'd0, 7'd3),  1, ST_MISSING);
        add_row(mk_op(FN_ALLOC,   8'd0,   8'd0, 1'b0, 7'd0,   7'd4),   1, ST_OK);
        add_row(mk_op(FN_ALLOC,   8'd1,   8'd0, 1'b1, 7'd126, 7'd3),   1, ST_OK);
        add_row(mk_op(FN_LOOKUP,  8'd1,   8'd0, 1'b1, 7'd127, 7'd0),   1, ST_OK);
        add_row(mk_op(FN_PLACE,   8'd0,   8'd0, 1'b0, 7'd0,   7'd4),   0, ST_OK);
        add_row(mk_op(FN_PLACE,   8'd1,   8'd0, 1'b1, 7'd126, 7'd3),   1, ST_MISSING);
        add_row(mk_op(FN_PLACE,   8'd1,   8'd0, 1'b1, 7'd0,   7'd1),   0, ST_OK);
        add_row(mk_op(FN_EXCH,    8'd0,   8'd2, 1'b0, 7'd0,   7'd1),   1, ST_MISSING);
        add_row(mk_op(FN_ALLOC,   8'd2,   8'd0, 1'b0, 7'd0,   7'd2),   1, ST_OK);
        add_row(mk_op(FN_EXCH,    8'd0,   8'd2, 1'b0, 7'd0,   7'd2),   0, ST_OK);
        add_row(mk_op(FN_ALLOC,   8'd254, 8'd0, 1'b0, 7'd5,   7'd0),   1, ST_OK);
        // long run clipped to 64, runs the table out of entries
        add_row(mk_op(FN_ALLOC,   8'd3,   8'd0, 1'b1, 7'd64,  7'd100), 1, ST_OK);
        add_row(mk_op(FN_ALLOC,   8'd254, 8'd0, 1'b0, 7'd9,   7'd1),   1, ST_OOM);
        add_row(mk_op(FN_COUNT,   8'd0,   8'd0, 1'b0, 7'd0,   7'd0),   1, ST_OK);
        add_row(mk_op(FN_FREE,    8'd3,   8'd0, 1'b0, 7'd0,   7'd0),   1, ST_OK);
        add_row(mk_op(FN_UNUSED,  8'd255, 8'd255, 1'b1, 7'd127, 7'd127), 1, ST_OK);
        add_row(mk_op(FN_RELEASE, 8'd0,   8'd0, 1'b0, 7'd2,   7'd2),   0, ST_OK);
        add_row(mk_op(FN_FREE,    FREE_MARK, 8'd0, 1'b0, 7'd0, 7'd0),  1, ST_OK);
        add_row(mk_op(FN_LOOKUP,  FREE_MARK, 8'd0, 1'b0, 7'd0, 7'd0),  1, ST_MISSING);
        add_row(mk_op(FN_PLACE,   FREE_MARK, 8'd0, 1'b0, 7'd0, 7'd1),  1, ST_MISSING);
        add_row(mk_op(FN_FREE,    8'd0,   8'd0, 1'b0, 7'd0,   7'd0),   1, ST_OK);
        add_row(mk_op(FN_FREE,    8'd1,   8'd0, 1'b0, 7'd0,   7'd0),   1, ST_OK);

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2 * ENTRIES) @(posedge clk);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            // settings: reset values, empty data region, empty code region, odd split
            case (ph)
                0: write_regs(7'd16, 7'd16, 32'd0, 32'd0);
                1: write_regs(7'd0, 7'd64, 32'h0000_1000, 32'hffff_fe00);
                2: write_regs(7'd64, 7'd0, 32'hffff_ffff, 32'h8000_0000);
                default: write_regs(7'd7, 7'd33, $urandom, $urandom);
            endcase
            // idle pattern: sender light/receiver heavy, swapped, then none
            case (ph)
                0: begin tx_idle_pct = 26; rx_idle_pct = 86; end
                1: begin tx_idle_pct = 86; rx_idle_pct = 26; end
                default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
            endcase
            if (ph == 0)
                foreach (dir_q[i])
                    send_op(dir_q[i].op, dir_q[i].chk, dir_q[i].status);
            // receiver stalls long in the no-idle phase while beats keep coming
            if (ph == 2)
                hold_go = 1'b1;
            for (int n = 0; n < RAND_ITEMS / PHASES; n++)
                send_op(rand_op(), 0, ST_OK);
            drain_wait();
        end

        $display("sent %0d operations, checked %0d result beats over %0d register settings",
                 items_sent, beats_seen, PHASES);
        $display("errors: %0d (%0d field mismatches)", errors, mismatches);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
